/* sv/grq_pkg.sv */
// grq_pkg: shared types and constants of the graph reachability query block
// controller command and status structs, input mode codes, field widths
// no dependencies
`timescale 1ns / 1ps

package grq_pkg;

  localparam int NUM_VERTICES_DEF = 16;
  localparam int MODE_W           = 2;
  localparam int VERTEX_W         = 4;

  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

  typedef struct packed {
    logic clear;
    logic add_edge;
    logic load_query;
    logic step;
    logic load_out;
  } grq_cmd_t;

  typedef struct packed {
    logic next_empty;
  } grq_status_t;

endpackage

/* sv/grq_datapath.sv */
// grq_datapath: adjacency bit matrix, visited and frontier sets, result register
// one frontier level expanded per step command; depends on grq_pkg
`timescale 1ns / 1ps

module grq_datapath
  import grq_pkg::*;
#(
  parameter int NUM_VERTICES = NUM_VERTICES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  grq_cmd_t            cmd_i,
  input  logic [VERTEX_W-1:0] source_i,
  input  logic [VERTEX_W-1:0] target_i,
  output grq_status_t         status_o,
  output logic                reachable_o
);

  logic [NUM_VERTICES-1:0] adj_q [NUM_VERTICES];
  logic [NUM_VERTICES-1:0] visited_q;
  logic [NUM_VERTICES-1:0] frontier_q;
  logic [NUM_VERTICES-1:0] goal_mask_q;
  logic                    reachable_q;

  logic [NUM_VERTICES-1:0] src_mask;
  logic [NUM_VERTICES-1:0] dst_mask;
  logic [NUM_VERTICES-1:0] succ;
  logic [NUM_VERTICES-1:0] next_set;

  // out-of-range vertex numbers shift out to an empty mask
  assign src_mask = NUM_VERTICES'(1) << source_i;
  assign dst_mask = NUM_VERTICES'(1) << target_i;

  always_comb begin
    succ = '0;
    for (int v = 0; v < NUM_VERTICES; v++) begin
      if (frontier_q[v]) begin
        succ = succ | adj_q[v];
      end
    end
    next_set = succ & ~visited_q;
  end

  assign status_o.next_empty = (next_set == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int v = 0; v < NUM_VERTICES; v++) begin
        adj_q[v] <= '0;
      end
      visited_q  <= '0;
      frontier_q <= '0;
    end else begin
      for (int v = 0; v < NUM_VERTICES; v++) begin
        if (cmd_i.clear) begin
          adj_q[v] <= '0;
        end else if (cmd_i.add_edge && src_mask[v]) begin
          adj_q[v] <= adj_q[v] | dst_mask;
        end
      end
      if (cmd_i.load_query) begin
        visited_q  <= src_mask;
        frontier_q <= src_mask;
      end else if (cmd_i.step) begin
        visited_q  <= visited_q | next_set;
        frontier_q <= next_set;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_query) begin
      goal_mask_q <= dst_mask;
    end
    if (cmd_i.load_out) begin
      reachable_q <= |(visited_q & goal_mask_q);
    end
  end

  assign reachable_o = reachable_q;

endmodule

/* sv/grq_controller.sv */
// grq_controller: handshake and sequencing state machine of the query block
// drives datapath commands from mode and status; depends on grq_pkg
`timescale 1ns / 1ps

module grq_controller
  import grq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [MODE_W-1:0] mode_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  grq_status_t       status_i,
  output grq_cmd_t          cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FIN
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;
  logic   accept;
  logic   out_free;

  assign accept   = in_valid_i && in_ready_q;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o            = '0;
    cmd_o.step       = (state_q == S_RUN);
    cmd_o.load_out   = (state_q == S_FIN) && out_free;
    if (accept) begin
      case (mode_i)
        MODE_CLEAR: cmd_o.clear      = 1'b1;
        MODE_ADD:   cmd_o.add_edge   = 1'b1;
        MODE_QUERY: cmd_o.load_query = 1'b1;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept && mode_i == MODE_QUERY) begin
            state_q    <= S_RUN;
            in_ready_q <= 1'b0;
          end
        end
        S_RUN: begin
          if (status_i.next_empty) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            in_ready_q  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q    <= S_IDLE;
          in_ready_q <= 1'b1;
        end
      endcase
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

endmodule

/* sv/graph_reachability_query.sv */
// graph_reachability_query: top level of the directed graph reachability block
// joins grq_controller and grq_datapath; depends on grq_pkg
//
// Usage: one input channel (in_valid_i / in_ready_o) carries mode_i, source_i
// and target_i. Mode clear removes every edge, mode add stores the edge
// source -> target, mode query asks whether target can be reached from source.
// Clear and add give no result; the unused mode is dropped.
// A query gives one transfer on the output channel (out_valid_o / out_ready_i)
// carrying reachable_o. A vertex always reaches itself; a vertex number not
// below NUM_VERTICES does not exist and answers 0.
// A query walks breadth-first levels until the frontier runs empty (1 to
// NUM_VERTICES levels); the frontier register expands one level per cycle
// through the OR of all adjacency rows selected by the frontier.
// The input reopens as the result is registered, so queries never overlap,
// while clear and add items are taken back to back.
// A stalled receiver holds the result in the output register; edit items are
// still accepted, and a following query waits before loading its result.
// Reset empties the graph and leaves the block ready with no result pending.
`timescale 1ns / 1ps

module graph_reachability_query
  import grq_pkg::*;
#(
  parameter int NUM_VERTICES = NUM_VERTICES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [MODE_W-1:0]   mode_i,
  input  logic [VERTEX_W-1:0] source_i,
  input  logic [VERTEX_W-1:0] target_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                reachable_o
);

  grq_cmd_t    cmd;
  grq_status_t status;

  grq_controller u_controller (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  grq_datapath #(
    .NUM_VERTICES (NUM_VERTICES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .source_i    (source_i),
    .target_i    (target_i),
    .status_o    (status),
    .reachable_o (reachable_o)
  );

  // never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> !(out_valid_o && !out_ready_i))
    else $error("result loaded over a pending result");

  // datapath commands are exclusive
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.clear, cmd.add_edge, cmd.load_query, cmd.step, cmd.load_out}))
    else $error("more than one datapath command");

  // a query transfer closes the input until its result is registered
  a_query_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && mode_i == MODE_QUERY) |=> !in_ready_o)
    else $error("input open during a query");

  // a result appears only after the walk finished
  a_valid_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.load_out))
    else $error("result valid without a load");

endmodule

/* tb/testbench.sv */
// testbench for graph_reachability_query: random graphs, chains and queries,
// checked against a breadth-first reachability scoreboard; depends on grq_pkg
`timescale 1ns / 1ps

module testbench;
  import grq_pkg::*;

  localparam int NV = NUM_VERTICES_DEF;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int ITEM_GOAL = 1200;

  class reach_scoreboard;
    logic [NV-1:0] edge_rows [NV];
    bit answers [$];
    int mismatches;

    function new();
      foreach (edge_rows[v]) edge_rows[v] = '0;
      mismatches = 0;
    endfunction

    function void note_item(logic [MODE_W-1:0] mode, logic [VERTEX_W-1:0] src,
                            logic [VERTEX_W-1:0] dst);
      logic [NV-1:0] seen;
      logic [NV-1:0] front;
      logic [NV-1:0] nxt;
      case (mode)
        MODE_CLEAR: begin
          foreach (edge_rows[v]) edge_rows[v] = '0;
        end
        MODE_ADD: begin
          if (src < NV && dst < NV) edge_rows[src][dst] = 1'b1;
        end
        MODE_QUERY: begin
          if (src >= NV || dst >= NV) begin
            answers.push_back(1'b0);
          end else begin
            seen = '0;
            seen[src] = 1'b1;
            front = seen;
            for (int lvl = 0; lvl < NV && front != '0; lvl++) begin
              nxt = '0;
              for (int v = 0; v < NV; v++) if (front[v]) nxt |= edge_rows[v];
              nxt &= ~seen;
              seen |= nxt;
              front = nxt;
            end
            answers.push_back(seen[dst]);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_answer(logic reachable);
      bit want;
      if (answers.size() == 0) begin
        $error("reachable: result transfer with no query pending, actual %0b", reachable);
        mismatches++;
      end else begin
        want = answers.pop_front();
        if (reachable !== want) begin
          $error("reachable: expected %0b, actual %0b", want, reachable);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [MODE_W-1:0]   mode_i = MODE_CLEAR;
  logic [VERTEX_W-1:0] source_i = '0;
  logic [VERTEX_W-1:0] target_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                reachable_o;

  reach_scoreboard board = new();
  int items_sent = 0;
  int tx_gap_max = 5;
  int rx_stall_max = 5;
  int order [NV];

  graph_reachability_query #(.NUM_VERTICES(NV)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .source_i    (source_i),
    .target_i    (target_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .reachable_o (reachable_o)
  );

  always #6 clk_i = ~clk_i;

  task automatic send_item(logic [MODE_W-1:0] mode, logic [VERTEX_W-1:0] src,
                           logic [VERTEX_W-1:0] dst);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    repeat (gap) @(negedge clk_i);
    in_valid_i = 1'b1;
    mode_i = mode;
    source_i = src;
    target_i = dst;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_item(mode, src, dst);
    if (mode != MODE_UNUSED) items_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic wait_drained();
    while (board.answers.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic random_query();
    send_item(MODE_QUERY, VERTEX_W'($urandom_range(0, NV - 1)),
              VERTEX_W'($urandom_range(0, NV - 1)));
  endtask

  // shuffled vertex order, used to lay out chains
  task automatic shuffle_order();
    int j;
    int t;
    foreach (order[i]) order[i] = i;
    for (int i = NV - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
  endtask

  task automatic chain_round();
    int len;
    int n_queries;
    len = $urandom_range(0, 3) == 0 ? NV : $urandom_range(2, NV);
    shuffle_order();
    send_item(MODE_CLEAR, VERTEX_W'($urandom), VERTEX_W'($urandom));
    if ($urandom_range(0, 1)) begin
      for (int i = 0; i < len - 1; i++)
        send_item(MODE_ADD, VERTEX_W'(order[i]), VERTEX_W'(order[i + 1]));
    end else begin
      for (int i = len - 2; i >= 0; i--)
        send_item(MODE_ADD, VERTEX_W'(order[i]), VERTEX_W'(order[i + 1]));
    end
    if ($urandom_range(0, 2) == 0)
      send_item(MODE_ADD, VERTEX_W'(order[len - 1]), VERTEX_W'(order[0]));
    send_item(MODE_QUERY, VERTEX_W'(order[0]), VERTEX_W'(order[len - 1]));
    send_item(MODE_QUERY, VERTEX_W'(order[len - 1]), VERTEX_W'(order[0]));
    n_queries = $urandom_range(0, 4);
    repeat (n_queries) begin
      if ($urandom_range(0, 1)) random_query();
      else send_item(MODE_QUERY, VERTEX_W'(order[$urandom_range(0, len - 1)]),
                     VERTEX_W'(order[$urandom_range(0, len - 1)]));
    end
  endtask

  task automatic graph_round();
    int n_edges;
    int n_queries;
    n_edges = $urandom_range(0, 24);
    n_queries = $urandom_range(1, 6);
    send_item(MODE_CLEAR, VERTEX_W'($urandom), VERTEX_W'($urandom));
    repeat (n_edges) send_item(MODE_ADD, VERTEX_W'($urandom_range(0, NV - 1)),
                               VERTEX_W'($urandom_range(0, NV - 1)));
    repeat (n_queries) random_query();
  endtask

  task automatic noise_round();
    int n;
    n = $urandom_range(3, 10);
    repeat (n) send_item(MODE_W'($urandom_range(0, 3)), VERTEX_W'($urandom),
                         VERTEX_W'($urandom));
  endtask

  // no clear: edits and queries interleaved on top of whatever is stored
  task automatic broken_round();
    int n;
    n = $urandom_range(3, 12);
    repeat (n) begin
      case ($urandom_range(0, 5))
        0: send_item(MODE_UNUSED, VERTEX_W'($urandom), VERTEX_W'($urandom));
        1, 2: random_query();
        default: send_item(MODE_ADD, VERTEX_W'($urandom), VERTEX_W'($urandom));
      endcase
    end
  endtask

  task automatic directed_items();
    send_item(MODE_QUERY, 4'd0, 4'd0);
    send_item(MODE_QUERY, 4'd0, 4'd15);
    send_item(MODE_UNUSED, 4'd15, 4'd15);
    send_item(MODE_ADD, 4'd0, 4'd15);
    send_item(MODE_ADD, 4'd0, 4'd15);
    send_item(MODE_ADD, 4'd3, 4'd3);
    send_item(MODE_QUERY, 4'd0, 4'd15);
    send_item(MODE_QUERY, 4'd15, 4'd0);
    send_item(MODE_QUERY, 4'd3, 4'd3);
    send_item(MODE_QUERY, 4'd3, 4'd4);
    send_item(MODE_QUERY, 4'd15, 4'd15);
    send_item(MODE_ADD, 4'd15, 4'd10);
    send_item(MODE_ADD, 4'd10, 4'd5);
    send_item(MODE_ADD, 4'd5, 4'd0);
    send_item(MODE_QUERY, 4'd0, 4'd5);
    send_item(MODE_QUERY, 4'd10, 4'd15);
    send_item(MODE_UNUSED, 4'd0, 4'd0);
    send_item(MODE_QUERY, 4'd5, 4'd3);
    send_item(MODE_CLEAR, 4'd15, 4'd15);
    send_item(MODE_QUERY, 4'd0, 4'd15);
    send_item(MODE_QUERY, 4'd10, 4'd10);
  endtask

  always begin
    @(negedge clk_i);
    out_ready_i = 1'b0;
    repeat ($urandom_range(0, rx_stall_max)) @(negedge clk_i);
    out_ready_i = 1'b1;
    do @(posedge clk_i); while (!out_valid_o);
    board.check_answer(reachable_o);
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    directed_items();
    wait_drained();
    while (items_sent < ITEM_GOAL) begin
      if ($urandom_range(0, 4) == 0) begin
        tx_gap_max = $urandom_range(0, 1) ? 5 : 0;
        rx_stall_max = $urandom_range(0, 1) ? 5 : 0;
      end
      case ($urandom_range(0, 9))
        0, 1, 2: chain_round();
        3, 4, 5, 6: graph_round();
        7: noise_round();
        default: broken_round();
      endcase
      if (items_sent > ITEM_GOAL / 2 && items_sent < ITEM_GOAL / 2 + 40) wait_drained();
    end
    wait_drained();
    repeat (40) @(posedge clk_i);
    if (board.answers.size() != 0) begin
      $error("reachable: %0d expected results never arrived", board.answers.size());
      board.mismatches++;
    end
    if (board.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
